FILE: design/pvs_pkg.sv
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared types and constants of the priority voice stealer.
// ----------------------------------------------------------------------------
`default_nettype none

package pvs_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_STOP   = 2'd1;
	localparam logic [1:0] KIND_UPDATE = 2'd2;
	localparam logic [1:0] KIND_QUERY  = 2'd3;

	// Reset priority of every slot, -1.0 in Q8.8.
	localparam logic signed [15:0] PRIO_RESET = -16'sd256;
	// Reset cull level, 1.0 in Q8.8.
	localparam logic signed [15:0] CULL_RESET = 16'sd256;
	// Distance given to an idle slot during a scan, beyond any real distance.
	localparam logic [16:0] IDLE_DIST = 17'h10000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic rd_en;
		logic apply;
	} pvs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
	} pvs_status_t;

endpackage

`default_nettype wire

FILE: design/pvs_ctrl.sv
// ----------------------------------------------------------------------------
// pvs_ctrl
// Sequencer of the voice stealer: accept, scan, drain, apply.
// ----------------------------------------------------------------------------
`default_nettype none

module pvs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         kind,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output pvs_pkg::pvs_cmd_t       cmd,
	input  wire pvs_pkg::pvs_status_t status
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_APPLY = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	assign cmd.capture = accept;
	assign cmd.rd_en   = (state_q == ST_SCAN);
	assign cmd.apply   = (state_q == ST_APPLY) && out_free;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == pvs_pkg::KIND_START || kind == pvs_pkg::KIND_QUERY)
						state_nxt = ST_SCAN;
					else
						state_nxt = ST_APPLY;
				end
			end
			ST_SCAN: begin
				if (status.scan_last)
					state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_APPLY;
			end
			ST_APPLY: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.apply)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: design/pvs_datapath.sv
// ----------------------------------------------------------------------------
// pvs_datapath
// Slot table, scan compare unit, write-back and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pvs_datapath #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pvs_pkg::pvs_cmd_t    cmd,
	output pvs_pkg::pvs_status_t      status,
	input  wire logic                 cfg_wr_en,
	input  wire logic signed [15:0]   cfg_wr_data,
	input  wire logic [1:0]           kind,
	input  wire logic signed [15:0]   new_priority,
	input  wire logic [3:0]           slot_index,
	input  wire logic [15:0]          distance,
	output logic [3:0]                chosen_slot,
	output logic                      evicted,
	output logic                      allowed
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// Slot RAMs, no reset: a written bit per slot stands in for it.
	logic signed [15:0] prio_mem [NUM_SLOTS];
	logic [15:0]        dist_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] busy_q;
	logic [NUM_SLOTS-1:0] written_q;
	logic signed [15:0] cull_q;

	// Captured item.
	logic [1:0]         kind_q;
	logic signed [15:0] prio_q;
	logic [3:0]         idx_q;
	logic [15:0]        dist_q;

	// Scan.
	logic [IDX_W-1:0]   rd_cnt_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic signed [15:0] prio_rd_s1;
	logic [15:0]        dist_rd_s1;
	logic               busy_s1;
	logic               written_s1;

	logic               have_q;
	logic               done_q;
	logic [IDX_W-1:0]   best_q;
	logic signed [15:0] best_p_q;
	logic [16:0]        best_d_q;
	logic               allowed_q;

	logic signed [15:0] eff_p;
	logic [16:0]        eff_d;
	logic               take;
	logic               in_range;
	logic [IDX_W-1:0]   wr_idx;

	logic [3:0]         chosen_q;
	logic               evicted_q;
	logic               allowed_out_q;

	assign status.scan_last = (rd_cnt_q == IDX_W'(NUM_SLOTS - 1));

	assign eff_p = written_s1 ? prio_rd_s1 : pvs_pkg::PRIO_RESET;
	assign eff_d = busy_s1 ? {1'b0, dist_rd_s1} : pvs_pkg::IDLE_DIST;

	always_comb begin
		if (!have_q)
			take = 1'b1;
		else
			take = (eff_p < best_p_q) ||
			       (eff_p == best_p_q && best_p_q < cull_q && busy_s1 && eff_d > best_d_q);
	end

	assign in_range = ({28'd0, idx_q} < 32'(NUM_SLOTS));
	assign wr_idx   = IDX_W'(idx_q);

	// Captured item and configuration.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			prio_q <= new_priority;
			idx_q  <= slot_index;
			dist_q <= distance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cull_q <= pvs_pkg::CULL_RESET;
		else if (cfg_wr_en)
			cull_q <= cfg_wr_data;
	end

	// RAM read and write ports.
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			prio_rd_s1 <= prio_mem[rd_cnt_q];
			dist_rd_s1 <= dist_mem[rd_cnt_q];
			busy_s1    <= busy_q[rd_cnt_q];
			written_s1 <= written_q[rd_cnt_q];
			idx_s1     <= rd_cnt_q;
		end
		if (cmd.apply) begin
			if (kind_q == pvs_pkg::KIND_START) begin
				prio_mem[best_q] <= prio_q;
				dist_mem[best_q] <= dist_q;
			end else if (kind_q == pvs_pkg::KIND_UPDATE && in_range) begin
				prio_mem[wr_idx] <= prio_q;
				dist_mem[wr_idx] <= dist_q;
			end
		end
	end

	// Slot flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= '0;
			written_q <= '0;
		end else if (cmd.apply) begin
			case (kind_q)
				pvs_pkg::KIND_START: begin
					busy_q[best_q]    <= 1'b1;
					written_q[best_q] <= 1'b1;
				end
				pvs_pkg::KIND_STOP: begin
					if (in_range)
						busy_q[wr_idx] <= 1'b0;
				end
				pvs_pkg::KIND_UPDATE: begin
					if (in_range)
						written_q[wr_idx] <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Scan counter and compare unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
			have_q    <= 1'b0;
			done_q    <= 1'b0;
			allowed_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.capture) begin
				rd_cnt_q  <= '0;
				have_q    <= 1'b0;
				done_q    <= 1'b0;
				allowed_q <= 1'b0;
			end else begin
				if (cmd.rd_en)
					rd_cnt_q <= rd_cnt_q + 1'b1;
				if (rd_vld_s1) begin
					if (eff_p < prio_q)
						allowed_q <= 1'b1;
					if (!done_q && take) begin
						have_q <= 1'b1;
						if (eff_p < 0)
							done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !done_q && take) begin
			best_q   <= idx_s1;
			best_p_q <= eff_p;
			best_d_q <= eff_d;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			chosen_q      <= '0;
			evicted_q     <= 1'b0;
			allowed_out_q <= 1'b0;
			if (kind_q == pvs_pkg::KIND_START) begin
				chosen_q  <= 4'(best_q);
				evicted_q <= busy_q[best_q];
			end else if (kind_q == pvs_pkg::KIND_QUERY) begin
				allowed_out_q <= allowed_q;
			end
		end
	end

	assign chosen_slot = chosen_q;
	assign evicted     = evicted_q;
	assign allowed     = allowed_out_q;

endmodule

`default_nettype wire

FILE: design/priority_voice_stealer_unit.sv
// ----------------------------------------------------------------------------
// priority_voice_stealer_unit
// Voice allocator over a table of playback slots with priority stealing.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Fields
//  in       input      in_valid / in_stall    kind, new_priority, slot_index, distance
//  out      output     out_valid / out_stall  chosen_slot, evicted, allowed
//  cfg      input      cfg_wr_en              cfg_wr_data (cull level)
//
// A start or query item passes through the scan and drain states to the
// apply state, which loads the result register. The scan reads one slot per
// cycle from the slot RAM, and the compare unit works on each slot in the
// cycle after its read. The next item can be accepted once the result is loaded.
// A stop or update item goes straight to the apply state to load its result.
// Reset clears all slots to idle with priority -1.0; the slot RAM itself is
// not cleared, a written bit per slot selects the reset value instead.
// A stalled result holds; the next item is taken while it waits, and only
// the final write-back waits for the result register to free up.
//
// Every item yields exactly one result item. Fields that do not apply to
// the item's kind read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_voice_stealer_unit #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         kind,
	input  wire logic signed [15:0] new_priority,
	input  wire logic [3:0]         slot_index,
	input  wire logic [15:0]        distance,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [3:0]              chosen_slot,
	output logic                    evicted,
	output logic                    allowed,
	input  wire logic               cfg_wr_en,
	input  wire logic signed [15:0] cfg_wr_data
);

	pvs_pkg::pvs_cmd_t    cmd;
	pvs_pkg::pvs_status_t status;

	// The controller sequences each item and owns the output valid flag.
	pvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// The datapath holds the slot table, the scan compare and the results.
	pvs_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.kind         (kind),
		.new_priority (new_priority),
		.slot_index   (slot_index),
		.distance     (distance),
		.chosen_slot  (chosen_slot),
		.evicted      (evicted),
		.allowed      (allowed)
	);

endmodule

`default_nettype wire

FILE: design/pvs_checker.sv
// ----------------------------------------------------------------------------
// pvs_checker
// Port-level checks of the voice stealer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pvs_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [3:0]         chosen_slot,
	input wire logic               evicted,
	input wire logic               allowed
);

	// A stalled result stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its fields.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(chosen_slot) && $stable(evicted) && $stable(allowed))
		else $error("result changed while stalled");

	// One item at a time: an accepted item blocks the input next cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted during work");

	// A query answer never carries start fields.
	a_query_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && allowed |-> !evicted && chosen_slot == 4'd0)
		else $error("query result mixed with start result");

endmodule

bind priority_voice_stealer_unit pvs_checker u_pvs_checker (.*);

`default_nettype wire
